@@ design/btsd_pkg.sv @@
// package: widths, action codes and constants for the bounded table search block
package btsd_pkg;
  localparam int unsigned DepthDefault = 16;
  localparam int unsigned ValW = 32;
  localparam int unsigned SumW = 36;
  localparam int unsigned PosW = 4;
  localparam int unsigned CntW = 5;
  localparam int unsigned ActW = 3;
  localparam logic signed [ValW-1:0] EmptyMark = -32'sd999;

  localparam logic [ActW-1:0] ActQuery = 3'd0;
  localparam logic [ActW-1:0] ActAppend = 3'd1;
  localparam logic [ActW-1:0] ActRemFirst = 3'd2;
  localparam logic [ActW-1:0] ActRemAll = 3'd3;
  localparam logic [ActW-1:0] ActClear = 3'd4;
endpackage

@@ design/btsd_ram.sv @@
// generic single-port-write ram with registered read
module btsd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ design/bounded_table_search_delete_mode.sv @@
// top level: packed table with append, remove, search and statistics
//
//  channel | valid     | ready     | payload
//  in      | in_valid_i| in_ready_o| action_i, value_i
//  out     | out_valid_o| out_ready_i| accepted_o .. is_full_o
//
// each word is processed in steps set by the single table read port: a stats
// pass over the entries held after the action, a count pass over the table for
// each entry to find the mode, then a restoring divide of one quotient bit per
// cycle over the sum bits (36 at the default depth) for the average.
// a removal first runs a compaction pass over the entries held before it.
// reset empties the table; entries need no clearing.
// the result register holds while out_ready_i is low; no new word is taken meanwhile.
module bounded_table_search_delete_mode #(
  parameter int unsigned DEPTH = btsd_pkg::DepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [btsd_pkg::ActW-1:0]         action_i,
  input  logic signed [btsd_pkg::ValW-1:0]  value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              accepted_o,
  output logic                              found_o,
  output logic [btsd_pkg::PosW-1:0]         position_o,
  output logic [btsd_pkg::CntW-1:0]         match_count_o,
  output logic [btsd_pkg::CntW-1:0]         entry_count_o,
  output logic signed [btsd_pkg::SumW-1:0]  sum_o,
  output logic signed [btsd_pkg::ValW-1:0]  average_o,
  output logic signed [btsd_pkg::ValW-1:0]  minimum_o,
  output logic signed [btsd_pkg::ValW-1:0]  maximum_o,
  output logic signed [btsd_pkg::ValW-1:0]  mode_o,
  output logic                              is_empty_o,
  output logic                              is_full_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);
  localparam int unsigned VW = btsd_pkg::ValW;
  localparam int unsigned SW = (btsd_pkg::ValW + AW > btsd_pkg::SumW) ?
                               btsd_pkg::ValW + AW : btsd_pkg::SumW;
  localparam int unsigned RamD = 1 << AW;

  typedef enum logic [3:0] {
    S_IDLE, S_CRD, S_CWAIT, S_CMP, S_SRD, S_SACC, S_MOUT, S_MIN, S_MEND,
    S_DIV, S_DONE
  } state_e;

  state_e state_q;
  logic [btsd_pkg::ActW-1:0] act_q;
  logic signed [VW-1:0] val_q;
  logic [NW-1:0] n_q, rd_q, wr_q, i_q, j_q;
  logic rem_q, acc_q, found_q;
  logic [NW-1:0] pos_q, mcnt_q, cnt_q, best_q;
  logic signed [SW-1:0] sum_q;
  logic signed [VW-1:0] mn_q, mx_q, md_q, cur_q;
  logic [SW-1:0] rem_div_q, quo_q;
  logic [5:0] dcnt_q;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [VW-1:0] wdata, rdata;
  logic signed [VW-1:0] e;

  btsd_ram #(.Width(VW), .Depth(RamD)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign e = signed'(rdata);
  assign in_ready_o = (state_q == S_IDLE);

  logic [SW-1:0] abs_sum, trial;
  logic [SW:0] sub;
  assign abs_sum = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign trial = {rem_div_q[SW-2:0], abs_sum[dcnt_q[5:0]]};
  assign sub = {1'b0, trial} - {{(SW+1-NW){1'b0}}, n_q};

  always_comb begin
    we = 1'b0;
    waddr = wr_q[AW-1:0];
    wdata = val_q;
    raddr = rd_q[AW-1:0];
    if (state_q == S_IDLE) begin
      we = in_valid_i && (action_i == btsd_pkg::ActAppend) && (n_q < NW'(DEPTH));
      waddr = n_q[AW-1:0];
      wdata = value_i;
    end else if (state_q == S_CMP) begin
      we = !((e == val_q) && (act_q == btsd_pkg::ActRemAll
             || (act_q == btsd_pkg::ActRemFirst && !rem_q)));
      wdata = e;
    end else if (state_q == S_SACC) begin
      raddr = AW'(rd_q + 1'b1);
    end else if (state_q == S_MIN) begin
      raddr = j_q[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q <= action_i;
            val_q <= value_i;
            acc_q <= 1'b0;
            rem_q <= 1'b0;
            rd_q <= '0;
            wr_q <= '0;
            state_q <= S_SRD;
            if (action_i == btsd_pkg::ActAppend && n_q < NW'(DEPTH)) begin
              n_q <= n_q + 1'b1;
              acc_q <= 1'b1;
            end else if (action_i == btsd_pkg::ActClear) begin
              n_q <= '0;
              acc_q <= 1'b1;
            end else if (action_i == btsd_pkg::ActRemFirst ||
                         action_i == btsd_pkg::ActRemAll) begin
              state_q <= S_CRD;
            end
          end
        end
        S_CRD: begin
          state_q <= (rd_q == n_q) ? S_CWAIT : S_CMP;
        end
        S_CMP: begin
          if (we) begin
            wr_q <= wr_q + 1'b1;
          end else begin
            rem_q <= 1'b1;
          end
          rd_q <= rd_q + 1'b1;
          state_q <= S_CRD;
        end
        S_CWAIT: begin
          n_q <= wr_q;
          acc_q <= rem_q;
          rd_q <= '0;
          state_q <= S_SRD;
        end
        S_SRD: begin
          found_q <= 1'b0;
          pos_q <= '0;
          mcnt_q <= '0;
          sum_q <= '0;
          mn_q <= btsd_pkg::EmptyMark;
          mx_q <= btsd_pkg::EmptyMark;
          md_q <= btsd_pkg::EmptyMark;
          best_q <= '0;
          i_q <= '0;
          state_q <= S_SACC;
        end
        S_SACC: begin
          if (rd_q == n_q) begin
            i_q <= '0;
            rd_q <= '0;
            state_q <= S_MOUT;
          end else begin
            if (e == val_q) begin
              if (!found_q) pos_q <= rd_q;
              found_q <= 1'b1;
              mcnt_q <= mcnt_q + 1'b1;
            end
            sum_q <= sum_q + SW'(e);
            if (rd_q == '0 || e < mn_q) mn_q <= e;
            if (rd_q == '0 || e > mx_q) mx_q <= e;
            rd_q <= rd_q + 1'b1;
          end
        end
        S_MOUT: begin
          if (i_q == n_q) begin
            rem_div_q <= '0;
            quo_q <= '0;
            dcnt_q <= 6'(SW - 1);
            state_q <= S_DIV;
          end else begin
            j_q <= '0;
            cnt_q <= '0;
            state_q <= S_MIN;
          end
        end
        S_MIN: begin
          if (rd_q != NW'(DEPTH)) begin
            rd_q <= NW'(DEPTH);
            cur_q <= e;
          end else begin
            if (j_q != '0) begin
              if (e == cur_q) cnt_q <= cnt_q + 1'b1;
            end
            if (j_q == n_q) begin
              state_q <= S_MEND;
            end
            j_q <= j_q + 1'b1;
          end
        end
        S_MEND: begin
          if (cnt_q > best_q) begin
            best_q <= cnt_q;
            md_q <= cur_q;
          end
          i_q <= i_q + 1'b1;
          rd_q <= i_q + 1'b1;
          state_q <= S_MOUT;
        end
        S_DIV: begin
          if (n_q == '0) begin
            quo_q <= '0;
            state_q <= S_DONE;
          end else begin
            if (!sub[SW]) begin
              rem_div_q <= sub[SW-1:0];
              quo_q <= {quo_q[SW-2:0], 1'b1};
            end else begin
              rem_div_q <= trial;
              quo_q <= {quo_q[SW-2:0], 1'b0};
            end
            if (dcnt_q == '0) state_q <= S_DONE;
            dcnt_q <= dcnt_q - 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid_o) begin
            out_valid_o <= 1'b1;
            accepted_o <= acc_q;
            found_o <= found_q;
            position_o <= btsd_pkg::PosW'(pos_q);
            match_count_o <= btsd_pkg::CntW'(mcnt_q);
            entry_count_o <= btsd_pkg::CntW'(n_q);
            sum_o <= btsd_pkg::SumW'(sum_q);
            average_o <= sum_q[SW-1] ? VW'(-quo_q) : VW'(quo_q);
            minimum_o <= mn_q;
            maximum_o <= mx_q;
            mode_o <= md_q;
            is_empty_o <= (n_q == '0);
            is_full_o <= (n_q == NW'(DEPTH));
          end else if (out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= NW'(DEPTH))
    else $error("entry count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == S_DONE)
    else $error("result shown outside done");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> wr_q <= rd_q)
    else $error("compaction write ahead of read");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while result pending");
endmodule
